/* rtl/pps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PID position step package
// Shared word types, status codes, register indexes and fixed-point constants
// for the position step controller.
// ----------------------------------------------------------------------------
package pps_pkg;

    // Move status codes as reported with every result word.
    typedef enum logic [1:0] {
        MS_RUN     = 2'd0,
        MS_REACHED = 2'd1,
        MS_TIMEOUT = 2'd2
    } t_move_status;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_WRAP = 3'd6;

    // Register reset values.
    localparam logic [14:0] OUT_LIMIT_RST = 15'd12000;
    localparam logic [15:0] TOLERANCE_RST = 16'd100;
    localparam logic [15:0] TIMEOUT_RST   = 16'd150;

    // Angle wrap constants, in hundredths of a degree.
    localparam logic [15:0] WRAP_HALF = 16'd18000;
    localparam logic [15:0] WRAP_FULL = 16'd36000;
    // floor(2^40 / 36000): the quotient estimate is exact or one low.
    localparam logic [24:0] WRAP_RECIP = 25'd30541989;

    // Saturation bounds of the integral and of the integral term.
    localparam logic signed [39:0] SUM_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SUM_MIN   = 40'sh80_0000_0000;
    localparam logic signed [63:0] ITERM_MAX = 64'sh0010_0000_0000_0000;
    localparam logic signed [63:0] ITERM_MIN = -64'sh0010_0000_0000_0000;

    // One control tick as it enters the block.
    typedef struct packed {
        logic               first_sample;
        logic signed [23:0] target;
        logic signed [23:0] measured;
    } t_in_word;

    // One drive command as it leaves the block.
    typedef struct packed {
        logic signed [15:0] drive;
        t_move_status       move_status;
    } t_out_word;

    // Load strobes for a three-stage section of the pipeline.
    typedef struct packed {
        logic first;
        logic second;
        logic third;
    } t_stage_ld;

endpackage : pps_pkg
`default_nettype wire

/* rtl/pps_wrap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Position error and angle wrap
// Forms target minus measured and, when enabled, folds it into plus or minus
// half a turn with a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module pps_wrap
    import pps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_stage_ld          i_ld,
    input  wire logic               i_wrap_en,
    input  wire logic               i_first,
    input  wire logic signed [23:0] i_target,
    input  wire logic signed [23:0] i_measured,
    output logic                    o_first,
    output logic signed [24:0]      o_error
);

    logic signed [24:0] diff;
    logic [24:0]        mag;
    logic [49:0]        prod;
    logic [24:0]        rem_wide;
    logic [15:0]        rem;
    logic [15:0]        fmod;
    logic signed [24:0] wrapped;

    logic               r_fs1, r_fs2, r_fs3;
    logic signed [24:0] r_e1, r_e2, r_e3;
    logic [24:0]        r_mag1;
    logic [8:0]         r_q1;
    logic [16:0]        r_rem2;

    // Stage one: exact difference, its magnitude and the quotient estimate.
    always_comb begin
        diff = {i_target[23], i_target} - {i_measured[23], i_measured};
        mag  = diff[24] ? 25'(-diff) : 25'(diff);
        prod = {25'd0, mag} * {25'd0, WRAP_RECIP};
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.first) begin
            r_fs1  <= i_first;
            r_e1   <= diff;
            r_mag1 <= mag;
            r_q1   <= prod[48:40];
        end
    end

    // Stage two: remainder before correction, below two full turns.
    assign rem_wide = r_mag1 - ({16'd0, r_q1} * {9'd0, WRAP_FULL});

    always_ff @(posedge i_clk) begin
        if (i_ld.second) begin
            r_fs2  <= r_fs1;
            r_e2   <= r_e1;
            r_rem2 <= rem_wide[16:0];
        end
    end

    // Stage three: floored remainder, then the fold into the half-turn range.
    // An error of exactly a half turn keeps the sign of the raw error.
    always_comb begin
        rem = (r_rem2 >= {1'b0, WRAP_FULL}) ? 16'(r_rem2 - {1'b0, WRAP_FULL})
                                            : r_rem2[15:0];
        fmod = (r_e2[24] && (rem != 16'd0)) ? 16'(WRAP_FULL - rem) : rem;
        if (r_e2 > $signed({9'd0, WRAP_HALF})) begin
            wrapped = (fmod > WRAP_HALF) ? $signed({9'd0, fmod}) - $signed({9'd0, WRAP_FULL})
                                         : $signed({9'd0, fmod});
        end else if (r_e2 < -$signed({9'd0, WRAP_HALF})) begin
            wrapped = (fmod >= WRAP_HALF) ? $signed({9'd0, fmod}) - $signed({9'd0, WRAP_FULL})
                                          : $signed({9'd0, fmod});
        end else begin
            wrapped = r_e2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.third) begin
            r_fs3 <= r_fs2;
            r_e3  <= i_wrap_en ? wrapped : r_e2;
        end
    end

    assign o_first = r_fs3;
    assign o_error = r_e3;

endmodule : pps_wrap
`default_nettype wire

/* rtl/pps_law.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PID control law
// Forms the three gain products, saturates the integral term, sums and
// scales the result from Q.16 to whole millivolts with floor rounding.
// ----------------------------------------------------------------------------
module pps_law
    import pps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_stage_ld          i_ld,
    input  wire logic [23:0]        i_prop_gain,
    input  wire logic [23:0]        i_integ_gain,
    input  wire logic [23:0]        i_deriv_gain,
    input  wire logic signed [24:0] i_error,
    input  wire logic signed [25:0] i_deriv,
    input  wire logic signed [39:0] i_sum,
    input  wire t_move_status       i_status,
    output logic signed [37:0]      o_scaled,
    output t_move_status            o_status
);

    logic signed [49:0] pterm;
    logic signed [50:0] dterm;
    logic signed [45:0] ilo;
    logic signed [44:0] ihi;
    logic signed [63:0] iterm;
    logic signed [53:0] iterm_sat;
    logic signed [51:0] pd_sum;
    logic signed [53:0] total;

    logic signed [49:0] r_pterm;
    logic signed [50:0] r_dterm;
    logic signed [45:0] r_ilo;
    logic signed [44:0] r_ihi;
    logic signed [53:0] r_iterm;
    logic signed [51:0] r_pd;
    logic signed [37:0] r_scaled;
    t_move_status       r_st5, r_st6, r_st7;

    // Stage one: products. The integral product is split at bit 20 of the sum.
    always_comb begin
        pterm = $signed({1'b0, i_prop_gain}) * i_error;
        dterm = $signed({1'b0, i_deriv_gain}) * $signed({i_deriv[25], i_deriv});
        ilo   = $signed({1'b0, i_integ_gain}) * $signed({1'b0, i_sum[19:0]});
        ihi   = $signed({1'b0, i_integ_gain}) * $signed(i_sum[39:20]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.first) begin
            r_pterm <= pterm;
            r_dterm <= dterm;
            r_ilo   <= ilo;
            r_ihi   <= ihi;
            r_st5   <= i_status;
        end
    end

    // Stage two: rejoin and saturate the integral term, add the other two.
    always_comb begin
        iterm = $signed({{19{r_ihi[44]}}, r_ihi} <<< 20)
              + $signed({{18{r_ilo[45]}}, r_ilo});
        if (iterm > ITERM_MAX) begin
            iterm_sat = ITERM_MAX[53:0];
        end else if (iterm < ITERM_MIN) begin
            iterm_sat = ITERM_MIN[53:0];
        end else begin
            iterm_sat = iterm[53:0];
        end
        pd_sum = $signed({{2{r_pterm[49]}}, r_pterm}) + $signed({r_dterm[50], r_dterm});
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.second) begin
            r_iterm <= iterm_sat;
            r_pd    <= pd_sum;
            r_st6   <= r_st5;
        end
    end

    // Stage three: final sum; an arithmetic shift rounds toward minus infinity.
    assign total = $signed({{2{r_pd[51]}}, r_pd}) + r_iterm;

    always_ff @(posedge i_clk) begin
        if (i_ld.third) begin
            r_scaled <= total[53:16];
            r_st7    <= r_st6;
        end
    end

    assign o_scaled = r_scaled;
    assign o_status = r_st7;

endmodule : pps_law
`default_nettype wire

/* rtl/pid_position_step_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PID position step controller
// One control tick in, one clamped drive command out, with move tracking:
// timeout, reach within tolerance, and a saturating integral.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  in        input      i_in_valid / o_in_stall   t_in_word  (first_sample, target, measured)
//  out       output     o_out_valid / i_out_stall t_out_word (drive, move_status)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One word is taken per cycle unless a stall at the output backs up to the input.
//  The pipeline holds the wrap divider (reciprocal multiply, remainder, fold), the
//  state update, and the split integral multiply with its saturated sum.
//  Reset restores the register defaults, clears the move state and empties the pipe.
//  A stalled result holds in the output register while empty stages behind it refill.
// ----------------------------------------------------------------------------
module pid_position_step_top
    import pps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [23:0]          i_cfg_data
);

    localparam int unsigned NSTG = 9;

    // Configuration registers.
    logic [23:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [14:0] r_out_limit;
    logic [15:0] r_tolerance, r_timeout;
    logic        r_angle_wrap;

    // Pipeline occupancy and flow.
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] ld;

    // Move state.
    logic signed [39:0] r_error_sum;
    logic signed [24:0] r_prev_error;
    logic [15:0]        r_tick_count;
    t_move_status       r_finished;

    logic signed [39:0] n_error_sum;
    logic signed [24:0] n_prev_error;
    logic [15:0]        n_tick_count;
    t_move_status       n_finished;
    t_move_status       n_status;
    logic signed [25:0] n_deriv;

    // Stage payloads.
    t_in_word           r_s0;
    logic signed [24:0] r_e4;
    logic signed [25:0] r_d4;
    logic signed [39:0] r_sum4;
    t_move_status       r_st4;
    t_out_word          r_out_word;

    logic               fs3;
    logic signed [24:0] e3;
    logic signed [37:0] scaled;
    t_move_status       st7;

    logic signed [39:0] sum_c;
    logic signed [24:0] prev_c;
    logic [15:0]        tick_c;
    t_move_status       fin_c;
    logic [24:0]        e_mag;
    logic signed [40:0] sum_wide;

    logic signed [37:0] lim;
    logic signed [37:0] drive_clamped;

    // Configuration writes are taken at any time.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_out_limit  <= OUT_LIMIT_RST;
            r_tolerance  <= TOLERANCE_RST;
            r_timeout    <= TIMEOUT_RST;
            r_angle_wrap <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                CFG_OUT_LIMIT:  r_out_limit  <= i_cfg_data[14:0];
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_data[15:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[15:0];
                CFG_ANGLE_WRAP: r_angle_wrap <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A stage can take a word when it is empty or its word moves on.
    always_comb begin
        rdy[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        ld[0] = i_in_valid && rdy[0];
        for (int k = 1; k < NSTG; k++) begin
            ld[k] = r_v[k-1] && rdy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_stall = !rdy[0];

    // Input register.
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0 <= i_in_word;
        end
    end

    // Error and wrap, stages one to three.
    pps_wrap u_wrap (
        .i_clk      (i_clk),
        .i_ld       ('{first: ld[1], second: ld[2], third: ld[3]}),
        .i_wrap_en  (r_angle_wrap),
        .i_first    (r_s0.first_sample),
        .i_target   (r_s0.target),
        .i_measured (r_s0.measured),
        .o_first    (fs3),
        .o_error    (e3)
    );

    // Move state update: finished check, timeout, tolerance, then the integral.
    always_comb begin
        sum_c  = fs3 ? '0 : r_error_sum;
        prev_c = fs3 ? '0 : r_prev_error;
        tick_c = fs3 ? '0 : r_tick_count;
        fin_c  = fs3 ? MS_RUN : r_finished;
        e_mag  = e3[24] ? 25'(-e3) : 25'(e3);
        sum_wide = {sum_c[39], sum_c} + {{16{e3[24]}}, e3};
        n_deriv  = {e3[24], e3} - {prev_c[24], prev_c};

        n_error_sum  = sum_c;
        n_prev_error = prev_c;
        n_tick_count = tick_c;
        n_finished   = fin_c;
        n_status     = MS_RUN;

        if (fin_c != MS_RUN) begin
            n_status = fin_c;
        end else if (tick_c >= r_timeout) begin
            n_finished = MS_TIMEOUT;
            n_status   = MS_TIMEOUT;
        end else if (e_mag <= {9'd0, r_tolerance}) begin
            n_finished = MS_REACHED;
            n_status   = MS_REACHED;
        end else begin
            if (tick_c != 16'hFFFF) begin
                n_tick_count = tick_c + 16'd1;
            end
            if (sum_wide[40] != sum_wide[39]) begin
                n_error_sum = sum_wide[40] ? SUM_MIN : SUM_MAX;
            end else begin
                n_error_sum = sum_wide[39:0];
            end
            n_prev_error = e3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
            r_tick_count <= '0;
            r_finished   <= MS_RUN;
        end else if (ld[4]) begin
            r_error_sum  <= n_error_sum;
            r_prev_error <= n_prev_error;
            r_tick_count <= n_tick_count;
            r_finished   <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_e4   <= e3;
            r_d4   <= n_deriv;
            r_sum4 <= n_error_sum;
            r_st4  <= n_status;
        end
    end

    // Control law, stages five to seven.
    pps_law u_law (
        .i_clk        (i_clk),
        .i_ld         ('{first: ld[5], second: ld[6], third: ld[7]}),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .i_error      (r_e4),
        .i_deriv      (r_d4),
        .i_sum        (r_sum4),
        .i_status     (r_st4),
        .o_scaled     (scaled),
        .o_status     (st7)
    );

    // Output register: clamp, and a zero drive once the move is over.
    always_comb begin
        lim = $signed({23'd0, r_out_limit});
        if (scaled > lim) begin
            drive_clamped = lim;
        end else if (scaled < -lim) begin
            drive_clamped = -lim;
        end else begin
            drive_clamped = scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[8]) begin
            r_out_word.drive       <= (st7 == MS_RUN) ? drive_clamped[15:0] : '0;
            r_out_word.move_status <= st7;
        end
    end

    assign o_out_valid = r_v[NSTG-1];
    assign o_out_word  = r_out_word;

    // A finished move always reports a zero drive.
    a_done_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.move_status != MS_RUN)) |-> (o_out_word.drive == 16'sd0))
        else $error("finished move reported a nonzero drive");

    // The drive never leaves the configured clamp.
    a_drive_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.drive <= $signed({1'b0, r_out_limit}))
                     && (o_out_word.drive >= -$signed({1'b0, r_out_limit}))))
        else $error("drive outside the configured limit");

    // A timed-out tick leaves the move marked as timed out.
    a_timeout_sticks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld[4] && (n_status == MS_TIMEOUT)) |=> (r_finished == MS_TIMEOUT))
        else $error("timeout not recorded in the move state");

    // A running tick always leaves a nonzero tick count behind.
    a_run_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld[4] && (n_status == MS_RUN)) |=> (r_tick_count != 16'd0))
        else $error("running tick did not advance the tick count");

endmodule : pid_position_step_top
`default_nettype wire
